// File: rtl/mlp_regression_inference_macros.svh
// assertion macros shared by the rtl of the network inference block
`ifndef MLP_REGRESSION_INFERENCE_MACROS_SVH
`define MLP_REGRESSION_INFERENCE_MACROS_SVH

// same-cycle implication checked on every clock edge outside reset
`define MRI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked on every clock edge outside reset
`define MRI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mri_pkg.sv
// types, constants, activation tables and fixed point helpers of the inference block
package mri_pkg;

   localparam int MAX_LAYERS = 8;
   localparam int MAX_WIDTH  = 32;
   localparam int FRAC_BITS  = 16;
   localparam int NFEAT      = 5;
   localparam int SEGS       = 256;
   localparam int TAB_FRAC   = FRAC_BITS - 4;
   localparam int LOG_ITERS  = 24;

   localparam logic FUNC_WRITE   = 1'b0;
   localparam logic FUNC_PREDICT = 1'b1;

   localparam logic [2:0] SEL_WEIGHT = 3'd0;
   localparam logic [2:0] SEL_BIAS   = 3'd1;
   localparam logic [2:0] SEL_MEAN   = 3'd2;
   localparam logic [2:0] SEL_SCALE  = 3'd3;
   localparam logic [2:0] SEL_ROWS   = 3'd4;
   localparam logic [2:0] SEL_COLS   = 3'd5;

   localparam logic [1:0] ACT_IDENTITY = 2'd0;
   localparam logic [1:0] ACT_RELU     = 2'd1;
   localparam logic [1:0] ACT_TANH     = 2'd2;
   localparam logic [1:0] ACT_SILU     = 2'd3;

   localparam logic [1:0] CSR_ACT_MODE    = 2'd0;
   localparam logic [1:0] CSR_LAYER_COUNT = 2'd1;
   localparam logic [1:0] CSR_OUT_MEAN    = 2'd2;
   localparam logic [1:0] CSR_OUT_STD     = 2'd3;

   localparam logic [1:0] CLAMP_NONE = 2'd0;
   localparam logic [1:0] CLAMP_ZERO = 2'd1;
   localparam logic [1:0] CLAMP_ONE  = 2'd2;

   localparam longint ONE30     = 64'sd1 <<< 30;
   localparam longint EXP_M8TH  = 64'sd947573834;
   localparam longint EXP_M16TH = 64'sd1008687096;
   localparam logic signed [32:0] LOG10_2_Q32 = 33'sd1292913986;

   localparam logic signed [31:0] ACT_HI = 32'sd8 <<< FRAC_BITS;
   localparam logic signed [31:0] ACT_LO = -ACT_HI;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC_BITS;

   typedef struct packed {
      logic              func;
      logic [2:0]        table_select;
      logic [2:0]        layer_index;
      logic [4:0]        row_index;
      logic [4:0]        col_index;
      logic signed [31:0] word_value;
      logic signed [31:0] feature_0;
      logic signed [31:0] feature_1;
      logic signed [31:0] feature_2;
      logic signed [31:0] feature_3;
      logic signed [31:0] feature_4;
   } req_type;

   typedef struct packed {
      logic [16:0] volume_fraction;
      logic [1:0]  clamp_code;
      logic        log_domain_error;
      logic        saturated;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LOG_SHIFT,
      ST_SQ_MUL,
      ST_SQ_UPD,
      ST_LOG_MUL,
      ST_LOG_WB,
      ST_NORM,
      ST_NORM_WB,
      ST_ROW_BIAS,
      ST_MAC,
      ST_DRAIN,
      ST_ACT_SAT,
      ST_ACT_MUL,
      ST_ACT_WB,
      ST_OUT_RD,
      ST_OUT_MUL,
      ST_OUT_FIN
   } state_type;

   typedef logic signed [31:0] tab_type [0:SEGS];

   // round half up then shift right, floor semantics
   function automatic longint rshr(input longint v, input int s);
      longint r;
      r = v;
      if (s > 0) begin
         r = (v + (64'sd1 <<< (s - 1))) >>> s;
      end
      return r;
   endfunction

   function automatic logic ovf32(input longint v);
      return (v > longint'(S32_MAX)) || (v < longint'(S32_MIN));
   endfunction

   function automatic logic signed [31:0] sat32(input longint v);
      logic signed [31:0] r;
      r = v[31:0];
      if (v > longint'(S32_MAX)) begin
         r = S32_MAX;
      end else if (v < longint'(S32_MIN)) begin
         r = S32_MIN;
      end
      return r;
   endfunction

   // restoring long division, only used while building the tables
   function automatic longint unsigned div_u64(input longint unsigned n,
                                               input longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], n[i]};
         if (r >= d) begin
            r = r - d;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic longint pow30(input longint base, input int n);
      longint unsigned p;
      p = longint'(ONE30);
      for (int i = 0; i < n; i++) begin
         p = (p * longint'(base) + (64'd1 << 29)) >> 30;
      end
      return longint'(p);
   endfunction

   // interpolation points of tanh or silu over [-8, 8]
   function automatic tab_type build_tab(input logic silu);
      tab_type tab;
      int      a;
      longint  t;
      longint  th;
      longint  s;
      longint  sg;
      longint  xr;
      for (int k = 0; k <= SEGS; k++) begin
         a  = (k < SEGS / 2) ? (SEGS / 2 - k) : (k - SEGS / 2);
         t  = pow30(EXP_M8TH, a);
         th = longint'(div_u64(longint'((ONE30 - t) <<< 30), longint'(ONE30 + t)));
         s  = pow30(EXP_M16TH, a);
         sg = longint'(div_u64(longint'(ONE30 <<< 30), longint'(ONE30 + s)));
         xr = longint'(k - SEGS / 2) * (64'sd1 <<< TAB_FRAC);
         if (k < SEGS / 2) begin
            th = -th;
            sg = ONE30 - sg;
         end
         if (silu) begin
            tab[k] = 32'(rshr(xr * sg, 30));
         end else begin
            tab[k] = 32'(rshr(th, 30 - FRAC_BITS));
         end
      end
      return tab;
   endfunction

   localparam tab_type TANH_TAB = build_tab(1'b0);
   localparam tab_type SILU_TAB = build_tab(1'b1);

endpackage

// File: rtl/mlp_regression_inference.sv
// Write beat: stores updated at the edge that takes the beat; no result.
// Predict beat: log and normalization first, then each layer row by row
// (one multiply-accumulate per cycle through the weight memory port), then
// the output scaling to the result.
// One beat at a time; a finished result waits in the output register.
// Synchronous active-high reset clears control and configuration, not the memories.
module mlp_regression_inference #(
   parameter int MAX_LAYERS = mri_pkg::MAX_LAYERS,
   parameter int MAX_WIDTH  = mri_pkg::MAX_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mri_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mri_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata
);

`include "mlp_regression_inference_macros.svh"

   localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int IW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int WDEPTH = 2 ** (LW + 2 * IW);
   localparam int BDEPTH = 2 ** (LW + IW);
   localparam int ADEPTH = 2 ** (IW + 1);

   mri_pkg::state_type state_ff, state_in;

   // configuration registers
   logic [1:0]         act_mode_ff;
   logic [3:0]         layer_count_ff;
   logic signed [31:0] out_mean_ff;
   logic signed [31:0] out_std_ff;

   // small stores in flops
   logic signed [31:0] mean_ff [mri_pkg::NFEAT];
   logic signed [31:0] inv_ff  [mri_pkg::NFEAT];
   logic [CW-1:0]      rows_ff [MAX_LAYERS];
   logic [CW-1:0]      cols_ff [MAX_LAYERS];

   // memories and registered read data
   logic signed [31:0] wmem [WDEPTH];
   logic signed [31:0] bmem [BDEPTH];
   logic signed [31:0] amem [ADEPTH];
   logic signed [31:0] w_rd_ff, b_rd_ff, a_rd_ff;

   // working registers
   mri_pkg::req_type   req_ff;
   logic [30:0]        m_ff;
   logic [4:0]         p_ff;
   logic [23:0]        frac_ff;
   logic [4:0]         sq_cnt_ff;
   logic signed [31:0] x4_ff;
   logic [2:0]         k_ff;
   logic               sat_ff, logerr_ff;
   logic [LW-1:0]      l_ff;
   logic [IW-1:0]      row_ff, col_ff;
   logic               cur_ff;
   logic [CW-1:0]      fill_ff [2];
   logic               v1_ff, v2_ff, z1_ff, f1_ff, f2_ff;
   logic signed [63:0] acc_ff;
   logic signed [31:0] y_ff;
   logic signed [63:0] prod_ff;
   mri_pkg::rsp_type   rsp_ff;
   logic               rsp_valid_ff;

   logic               req_take, wr_beat, pred_beat;
   logic               lay_ok, row_ok, col_ok, feat_ok;
   logic [CW-1:0]      cnt_val;
   logic [LW-1:0]      nl_m1;
   logic [CW-1:0]      rows_cur, cols_cur;
   logic               col_last, row_last, l_last;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_full;
   logic signed [31:0] x_sel, d_norm, l2;
   logic signed [63:0] diff_norm, norm_res, acc_add, vf;
   logic [31:0]        msq;
   logic signed [32:0] t_act;
   logic [7:0]         tab_idx;
   logic [8:0]         tab_idx_hi;
   logic [mri_pkg::TAB_FRAC-1:0] tab_frac;
   logic signed [31:0] tab_lo, tab_hi, act_res;
   logic signed [32:0] tab_d;
   logic               rsp_free;

   // input handshake
   assign req_take  = req_valid && !req_stall;
   assign wr_beat   = req_take && (req_data.func == mri_pkg::FUNC_WRITE);
   assign pred_beat = req_take && (req_data.func == mri_pkg::FUNC_PREDICT);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // write address checks and count clamp
   always_comb begin
      lay_ok  = 32'(req_data.layer_index) < 32'(MAX_LAYERS);
      row_ok  = 32'(req_data.row_index) < 32'(MAX_WIDTH);
      col_ok  = 32'(req_data.col_index) < 32'(MAX_WIDTH);
      feat_ok = 32'(req_data.row_index) < 32'(mri_pkg::NFEAT);
      if (req_data.word_value < 32'sd1) begin
         cnt_val = CW'(1);
      end else if (req_data.word_value > 32'(MAX_WIDTH)) begin
         cnt_val = CW'(MAX_WIDTH);
      end else begin
         cnt_val = CW'(req_data.word_value);
      end
   end

   // layer bookkeeping
   always_comb begin
      if (layer_count_ff == 4'd0) begin
         nl_m1 = '0;
      end else if (32'(layer_count_ff) > 32'(MAX_LAYERS)) begin
         nl_m1 = LW'(MAX_LAYERS - 1);
      end else begin
         nl_m1 = LW'(layer_count_ff - 4'd1);
      end
      rows_cur = rows_ff[l_ff];
      cols_cur = cols_ff[l_ff];
      col_last = (CW'(col_ff) + CW'(1)) == cols_cur;
      row_last = (CW'(row_ff) + CW'(1)) == rows_cur;
      l_last   = l_ff == nl_m1;
   end

   // log, normalization, accumulation and output scaling arithmetic
   always_comb begin
      case (k_ff)
         3'd0:    x_sel = req_ff.feature_0;
         3'd1:    x_sel = req_ff.feature_1;
         3'd2:    x_sel = req_ff.feature_2;
         3'd3:    x_sel = req_ff.feature_3;
         default: x_sel = x4_ff;
      endcase
      diff_norm = 64'(x_sel) - 64'(mean_ff[k_ff]);
      d_norm    = mri_pkg::sat32(diff_norm);
      norm_res  = mri_pkg::rshr(prod_ff, mri_pkg::FRAC_BITS);
      l2  = ((32'($signed({1'b0, p_ff})) - 32'(mri_pkg::FRAC_BITS)) <<< mri_pkg::LOG_ITERS)
            + 32'($signed({1'b0, frac_ff}));
      msq = prod_ff[61:30];
      acc_add = mri_pkg::rshr(prod_ff, mri_pkg::FRAC_BITS);
      vf = mri_pkg::rshr(prod_ff, mri_pkg::FRAC_BITS) + 64'(out_mean_ff);
   end

   // activation: relu or identity, tanh and silu by table interpolation
   always_comb begin
      t_act      = 33'(y_ff) + 33'(mri_pkg::ACT_HI);
      tab_idx    = t_act[mri_pkg::TAB_FRAC+7:mri_pkg::TAB_FRAC];
      tab_idx_hi = {1'b0, tab_idx} + 9'd1;
      tab_frac   = t_act[mri_pkg::TAB_FRAC-1:0];
      if (act_mode_ff == mri_pkg::ACT_SILU) begin
         tab_lo = mri_pkg::SILU_TAB[tab_idx];
         tab_hi = mri_pkg::SILU_TAB[tab_idx_hi];
      end else begin
         tab_lo = mri_pkg::TANH_TAB[tab_idx];
         tab_hi = mri_pkg::TANH_TAB[tab_idx_hi];
      end
      tab_d = 33'(tab_hi) - 33'(tab_lo);
      case (act_mode_ff)
         mri_pkg::ACT_RELU: begin
            act_res = (y_ff < 32'sd0) ? 32'sd0 : y_ff;
         end
         mri_pkg::ACT_TANH: begin
            if (y_ff < mri_pkg::ACT_LO) begin
               act_res = mri_pkg::TANH_TAB[0];
            end else if (y_ff >= mri_pkg::ACT_HI) begin
               act_res = mri_pkg::TANH_TAB[mri_pkg::SEGS];
            end else begin
               act_res = tab_lo + 32'(mri_pkg::rshr(prod_ff, mri_pkg::TAB_FRAC));
            end
         end
         mri_pkg::ACT_SILU: begin
            if (y_ff < mri_pkg::ACT_LO) begin
               act_res = 32'sd0;
            end else if (y_ff >= mri_pkg::ACT_HI) begin
               act_res = y_ff;
            end else begin
               act_res = tab_lo + 32'(mri_pkg::rshr(prod_ff, mri_pkg::TAB_FRAC));
            end
         end
         default: act_res = y_ff;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mri_pkg::ST_IDLE: begin
            if (pred_beat) begin
               state_in = (req_data.feature_4 <= 32'sd0) ? mri_pkg::ST_NORM
                                                         : mri_pkg::ST_LOG_SHIFT;
            end
         end
         mri_pkg::ST_LOG_SHIFT: begin
            if (!(p_ff != 5'd0 && !m_ff[30])) begin
               state_in = mri_pkg::ST_SQ_MUL;
            end
         end
         mri_pkg::ST_SQ_MUL: state_in = mri_pkg::ST_SQ_UPD;
         mri_pkg::ST_SQ_UPD: begin
            state_in = (sq_cnt_ff == 5'(mri_pkg::LOG_ITERS - 1)) ? mri_pkg::ST_LOG_MUL
                                                                 : mri_pkg::ST_SQ_MUL;
         end
         mri_pkg::ST_LOG_MUL: state_in = mri_pkg::ST_LOG_WB;
         mri_pkg::ST_LOG_WB:  state_in = mri_pkg::ST_NORM;
         mri_pkg::ST_NORM:    state_in = mri_pkg::ST_NORM_WB;
         mri_pkg::ST_NORM_WB: begin
            state_in = (k_ff == 3'(mri_pkg::NFEAT - 1)) ? mri_pkg::ST_ROW_BIAS
                                                        : mri_pkg::ST_NORM;
         end
         mri_pkg::ST_ROW_BIAS: state_in = mri_pkg::ST_MAC;
         mri_pkg::ST_MAC: begin
            if (col_last) begin
               state_in = mri_pkg::ST_DRAIN;
            end
         end
         mri_pkg::ST_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               state_in = mri_pkg::ST_ACT_SAT;
            end
         end
         mri_pkg::ST_ACT_SAT: state_in = mri_pkg::ST_ACT_MUL;
         mri_pkg::ST_ACT_MUL: state_in = mri_pkg::ST_ACT_WB;
         mri_pkg::ST_ACT_WB: begin
            state_in = (row_last && l_last) ? mri_pkg::ST_OUT_RD : mri_pkg::ST_ROW_BIAS;
         end
         mri_pkg::ST_OUT_RD:  state_in = mri_pkg::ST_OUT_MUL;
         mri_pkg::ST_OUT_MUL: state_in = mri_pkg::ST_OUT_FIN;
         mri_pkg::ST_OUT_FIN: begin
            if (rsp_free) begin
               state_in = mri_pkg::ST_IDLE;
            end
         end
         default: state_in = mri_pkg::ST_IDLE;
      endcase
   end

   // state outputs: handshake and shared multiplier operands
   always_comb begin
      req_stall = 1'b1;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         mri_pkg::ST_IDLE: req_stall = 1'b0;
         mri_pkg::ST_SQ_MUL: begin
            mul_a = {2'b00, m_ff};
            mul_b = {2'b00, m_ff};
         end
         mri_pkg::ST_LOG_MUL: begin
            mul_a = 33'(l2);
            mul_b = mri_pkg::LOG10_2_Q32;
         end
         mri_pkg::ST_NORM: begin
            mul_a = 33'(d_norm);
            mul_b = 33'(inv_ff[k_ff]);
         end
         mri_pkg::ST_MAC, mri_pkg::ST_DRAIN: begin
            mul_a = 33'(w_rd_ff);
            mul_b = z1_ff ? 33'sd0 : 33'(a_rd_ff);
         end
         mri_pkg::ST_ACT_MUL: begin
            mul_a = tab_d;
            mul_b = 33'($signed({1'b0, tab_frac}));
         end
         mri_pkg::ST_OUT_MUL: begin
            mul_a = 33'(a_rd_ff);
            mul_b = 33'(out_std_ff);
         end
         default: mul_a = '0;
      endcase
   end

   assign mul_full = mul_a * mul_b;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= mri_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         act_mode_ff    <= mri_pkg::ACT_IDENTITY;
         layer_count_ff <= 4'd1;
         out_mean_ff    <= 32'sd0;
         out_std_ff     <= mri_pkg::Q_ONE;
      end else begin
         state_ff <= state_in;
         v1_ff    <= state_ff == mri_pkg::ST_MAC;
         v2_ff    <= v1_ff;
         if (state_ff == mri_pkg::ST_OUT_FIN && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               mri_pkg::CSR_ACT_MODE:    act_mode_ff    <= csr_wdata[1:0];
               mri_pkg::CSR_LAYER_COUNT: layer_count_ff <= csr_wdata[3:0];
               mri_pkg::CSR_OUT_MEAN:    out_mean_ff    <= csr_wdata;
               mri_pkg::CSR_OUT_STD:     out_std_ff     <= csr_wdata;
               default:                  out_std_ff     <= out_std_ff;
            endcase
         end
      end
   end

   // small stores written by write beats
   always_ff @(posedge clock) begin
      if (wr_beat) begin
         unique case (req_data.table_select)
            mri_pkg::SEL_MEAN: begin
               if (feat_ok) mean_ff[3'(req_data.row_index)] <= req_data.word_value;
            end
            mri_pkg::SEL_SCALE: begin
               if (feat_ok) inv_ff[3'(req_data.row_index)] <= req_data.word_value;
            end
            mri_pkg::SEL_ROWS: begin
               if (lay_ok) rows_ff[LW'(req_data.layer_index)] <= cnt_val;
            end
            mri_pkg::SEL_COLS: begin
               if (lay_ok) cols_ff[LW'(req_data.layer_index)] <= cnt_val;
            end
            default: begin
            end
         endcase
      end
   end

   // weight memory
   always_ff @(posedge clock) begin
      if (wr_beat && req_data.table_select == mri_pkg::SEL_WEIGHT && lay_ok && row_ok && col_ok) begin
         wmem[{LW'(req_data.layer_index), IW'(req_data.row_index),
               IW'(req_data.col_index)}] <= req_data.word_value;
      end
      if (state_ff == mri_pkg::ST_MAC) begin
         w_rd_ff <= wmem[{l_ff, row_ff, col_ff}];
      end
   end

   // bias memory
   always_ff @(posedge clock) begin
      if (wr_beat && req_data.table_select == mri_pkg::SEL_BIAS && lay_ok && row_ok) begin
         bmem[{LW'(req_data.layer_index), IW'(req_data.row_index)}] <= req_data.word_value;
      end
      if (state_ff == mri_pkg::ST_ROW_BIAS) begin
         b_rd_ff <= bmem[{l_ff, row_ff}];
      end
   end

   // activation memory, two banks
   always_ff @(posedge clock) begin
      if (state_ff == mri_pkg::ST_NORM_WB) begin
         amem[{1'b0, IW'(k_ff)}] <= mri_pkg::sat32(norm_res);
      end else if (state_ff == mri_pkg::ST_ACT_WB) begin
         amem[{~cur_ff, row_ff}] <= act_res;
      end
      if (state_ff == mri_pkg::ST_MAC) begin
         a_rd_ff <= amem[{cur_ff, col_ff}];
      end else if (state_ff == mri_pkg::ST_OUT_RD) begin
         a_rd_ff <= amem[{cur_ff, IW'(0)}];
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_full[63:0];
      z1_ff   <= CW'(col_ff) >= fill_ff[cur_ff];
      f1_ff   <= col_ff == '0;
      f2_ff   <= f1_ff;
      if (v2_ff) begin
         acc_ff <= (f2_ff ? 64'(b_rd_ff) : acc_ff) + acc_add;
      end
      unique case (state_ff)
         mri_pkg::ST_IDLE: begin
            if (pred_beat) begin
               req_ff    <= req_data;
               m_ff      <= req_data.feature_4[30:0];
               p_ff      <= 5'd30;
               frac_ff   <= '0;
               sq_cnt_ff <= '0;
               k_ff      <= '0;
               sat_ff    <= 1'b0;
               logerr_ff <= req_data.feature_4 <= 32'sd0;
               x4_ff     <= mri_pkg::S32_MIN;
            end
         end
         mri_pkg::ST_LOG_SHIFT: begin
            if (p_ff != 5'd0 && !m_ff[30]) begin
               m_ff <= {m_ff[29:0], 1'b0};
               p_ff <= p_ff - 5'd1;
            end
         end
         mri_pkg::ST_SQ_UPD: begin
            if (msq[31]) begin
               frac_ff[5'(mri_pkg::LOG_ITERS - 1) - sq_cnt_ff] <= 1'b1;
               m_ff <= msq[31:1];
            end else begin
               m_ff <= msq[30:0];
            end
            sq_cnt_ff <= sq_cnt_ff + 5'd1;
         end
         mri_pkg::ST_LOG_WB: begin
            x4_ff <= 32'(mri_pkg::rshr(prod_ff, 56 - mri_pkg::FRAC_BITS));
         end
         mri_pkg::ST_NORM: begin
            if (mri_pkg::ovf32(diff_norm)) sat_ff <= 1'b1;
         end
         mri_pkg::ST_NORM_WB: begin
            if (mri_pkg::ovf32(norm_res)) sat_ff <= 1'b1;
            k_ff <= k_ff + 3'd1;
            if (k_ff == 3'(mri_pkg::NFEAT - 1)) begin
               fill_ff[0] <= CW'(mri_pkg::NFEAT);
               cur_ff     <= 1'b0;
               l_ff       <= '0;
               row_ff     <= '0;
            end
         end
         mri_pkg::ST_ROW_BIAS: col_ff <= '0;
         mri_pkg::ST_MAC: begin
            if (!col_last) col_ff <= col_ff + IW'(1);
         end
         mri_pkg::ST_ACT_SAT: begin
            y_ff <= mri_pkg::sat32(acc_ff);
            if (mri_pkg::ovf32(acc_ff)) sat_ff <= 1'b1;
         end
         mri_pkg::ST_ACT_WB: begin
            if (row_last) begin
               fill_ff[~cur_ff] <= rows_cur;
               cur_ff <= ~cur_ff;
               row_ff <= '0;
               if (!l_last) l_ff <= l_ff + LW'(1);
            end else begin
               row_ff <= row_ff + IW'(1);
            end
         end
         mri_pkg::ST_OUT_FIN: begin
            if (rsp_free) begin
               rsp_ff.log_domain_error <= logerr_ff;
               rsp_ff.saturated        <= sat_ff;
               if (vf < 64'sd0) begin
                  rsp_ff.volume_fraction <= '0;
                  rsp_ff.clamp_code      <= mri_pkg::CLAMP_ZERO;
               end else if (vf > 64'(mri_pkg::Q_ONE)) begin
                  rsp_ff.volume_fraction <= 17'(mri_pkg::Q_ONE);
                  rsp_ff.clamp_code      <= mri_pkg::CLAMP_ONE;
               end else begin
                  rsp_ff.volume_fraction <= vf[16:0];
                  rsp_ff.clamp_code      <= mri_pkg::CLAMP_NONE;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `MRI_ASSERT_IMP(a_ready_pipe_empty, clock, reset, !req_stall, !v1_ff && !v2_ff, "beat taken with mac pipeline busy")
   `MRI_ASSERT_IMP(a_act_after_drain, clock, reset, state_ff == mri_pkg::ST_ACT_SAT, !v1_ff && !v2_ff, "activation before accumulation drained")
   `MRI_ASSERT_IMP(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff), $past(state_ff == mri_pkg::ST_OUT_FIN), "result raised outside final state")
   `MRI_ASSERT_IMP(a_sq_count, clock, reset, state_ff == mri_pkg::ST_SQ_UPD, sq_cnt_ff < 5'(mri_pkg::LOG_ITERS), "log squaring ran past its count")
   `MRI_ASSERT_NEXT(a_fin_done, clock, reset, state_ff == mri_pkg::ST_OUT_FIN && rsp_free, rsp_valid_ff && !req_stall, "result not loaded at finish")

endmodule

// File: verif/mlp_regression_inference_test.sv
// testbench for the network inference block: random networks, predictions and a scoreboard
`timescale 1ns / 1ps

import mri_pkg::*;

// keeps a copy of the network stores and settings and predicts each prediction beat
class volume_fraction_board;
   logic signed [31:0] weights [0:8191];
   logic signed [31:0] biases [0:255];
   logic signed [31:0] feat_mean [0:4];
   logic signed [31:0] feat_scale [0:4];
   int                 row_cnt [0:7];
   int                 col_cnt [0:7];
   logic [1:0]         act_mode;
   logic [3:0]         layer_cnt;
   logic signed [31:0] out_mean;
   logic signed [31:0] out_std;
   logic signed [31:0] tanh_pts [0:256];
   logic signed [31:0] silu_pts [0:256];
   rsp_type            expected_fractions [$];
   bit                 sat_seen;
   int                 mismatches;
   int                 predicts;
   int                 writes;
   int                 clamp_seen [0:2];
   int                 log_errors;
   int                 sat_results;

   function new();
      longint one;
      longint t;
      longint th;
      longint s;
      longint sg;
      longint xr;
      int     a;
      one = 64'sd1 <<< 30;
      for (int k = 0; k <= 256; k++) begin
         a  = (k < 128) ? 128 - k : k - 128;
         t  = pow_q30(EXP_M8TH, a);
         th = ((one - t) <<< 30) / (one + t);
         s  = pow_q30(EXP_M16TH, a);
         sg = (one <<< 30) / (one + s);
         xr = longint'(k - 128) * 4096;
         if (k < 128) begin
            th = -th;
            sg = one - sg;
         end
         tanh_pts[k] = 32'(round_shift(th, 14));
         silu_pts[k] = 32'(round_shift(xr * sg, 30));
      end
      act_mode   = ACT_IDENTITY;
      layer_cnt  = 4'd1;
      out_mean   = '0;
      out_std    = Q_ONE;
      mismatches = 0;
      predicts   = 0;
      writes     = 0;
      log_errors = 0;
      sat_results = 0;
      clamp_seen = '{0, 0, 0};
   endfunction

   // repeated rounded q30 multiply of a base
   function longint pow_q30(longint base, int n);
      longint p;
      p = 64'sd1 <<< 30;
      for (int i = 0; i < n; i++) begin
         p = (p * base + (64'sd1 <<< 29)) >>> 30;
      end
      return p;
   endfunction

   // round half toward plus infinity, then floor shift
   function longint round_shift(longint v, int s);
      if (s == 0) begin
         return v;
      end
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function logic signed [31:0] clip32(longint v);
      if (v > longint'(S32_MAX)) begin
         sat_seen = 1'b1;
         return S32_MAX;
      end
      if (v < longint'(S32_MIN)) begin
         sat_seen = 1'b1;
         return S32_MIN;
      end
      return 32'(v);
   endfunction

   function logic signed [31:0] interp(bit use_silu, logic signed [31:0] y);
      longint tt;
      longint fr;
      longint d;
      longint base;
      int     idx;
      tt  = longint'(y) + (64'sd8 <<< 16);
      idx = int'(tt >>> 12);
      fr  = tt & 64'sd4095;
      if (use_silu) begin
         base = silu_pts[idx];
         d    = longint'(silu_pts[idx + 1]) - base;
      end else begin
         base = tanh_pts[idx];
         d    = longint'(tanh_pts[idx + 1]) - base;
      end
      return 32'(base + round_shift(d * fr, 12));
   endfunction

   function logic signed [31:0] activate(logic signed [31:0] y);
      case (act_mode)
         ACT_RELU: return (y < 0) ? 32'sd0 : y;
         ACT_TANH: begin
            if (y < ACT_LO) return tanh_pts[0];
            if (y >= ACT_HI) return tanh_pts[256];
            return interp(1'b0, y);
         end
         ACT_SILU: begin
            if (y < ACT_LO) return 32'sd0;
            if (y >= ACT_HI) return y;
            return interp(1'b1, y);
         end
         default: return y;
      endcase
   endfunction

   // base-10 log through log2 by mantissa squaring
   function logic signed [31:0] log10_q(logic signed [31:0] x);
      longint unsigned r;
      longint unsigned m;
      longint          fr;
      longint          l2;
      int              p;
      r  = longint'(x);
      p  = 30;
      fr = 0;
      while (p > 0 && r[p] == 1'b0) p--;
      m = r << (30 - p);
      for (int i = 1; i <= 24; i++) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            fr = fr | (64'sd1 <<< (24 - i));
            m  = m >> 1;
         end
      end
      l2 = longint'(p - 16) * (64'sd1 <<< 24) + fr;
      return 32'(round_shift(l2 * longint'(LOG10_2_Q32), 40));
   endfunction

   function int clamp_count(logic signed [31:0] v);
      if (v < 1) return 1;
      if (v > 32) return 32;
      return int'(v);
   endfunction

   function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
         CSR_ACT_MODE:    act_mode  = v[1:0];
         CSR_LAYER_COUNT: layer_cnt = v[3:0];
         CSR_OUT_MEAN:    out_mean  = v;
         default:         out_std   = v;
      endcase
   endfunction

   // accepted request beat: table write or prediction
   function void note_beat(req_type r);
      logic signed [31:0] f [0:4];
      logic signed [31:0] cur_v [0:31];
      logic signed [31:0] nxt_v [0:31];
      logic signed [31:0] x;
      logic signed [31:0] d;
      longint             acc;
      longint             vf;
      int                 nl;
      bit                 logerr;
      rsp_type            e;
      if (r.func == FUNC_WRITE) begin
         writes++;
         case (r.table_select)
            SEL_WEIGHT: weights[{r.layer_index, r.row_index, r.col_index}] = r.word_value;
            SEL_BIAS:   biases[{r.layer_index, r.row_index}] = r.word_value;
            SEL_MEAN:   if (r.row_index < 5) feat_mean[r.row_index] = r.word_value;
            SEL_SCALE:  if (r.row_index < 5) feat_scale[r.row_index] = r.word_value;
            SEL_ROWS:   row_cnt[r.layer_index] = clamp_count(r.word_value);
            SEL_COLS:   col_cnt[r.layer_index] = clamp_count(r.word_value);
            default: ;
         endcase
         return;
      end
      predicts++;
      f = '{r.feature_0, r.feature_1, r.feature_2, r.feature_3, r.feature_4};
      cur_v    = '{default: '0};
      sat_seen = 1'b0;
      logerr   = 1'b0;
      // log of the last feature, then normalization
      for (int i = 0; i < 5; i++) begin
         x = f[i];
         if (i == 4) begin
            if (x <= 0) begin
               logerr = 1'b1;
               x = S32_MIN;
            end else begin
               x = log10_q(x);
            end
         end
         d = clip32(longint'(x) - longint'(feat_mean[i]));
         cur_v[i] = clip32(round_shift(longint'(d) * longint'(feat_scale[i]), 16));
      end
      // forward pass
      nl = (layer_cnt < 1) ? 1 : int'(layer_cnt);
      if (nl > 8) nl = 8;
      for (int l = 0; l < nl; l++) begin
         nxt_v = '{default: '0};
         for (int i = 0; i < row_cnt[l]; i++) begin
            acc = biases[l * 32 + i];
            for (int j = 0; j < col_cnt[l]; j++) begin
               acc += round_shift(longint'(weights[(l * 32 + i) * 32 + j])
                                  * longint'(cur_v[j]), 16);
            end
            nxt_v[i] = activate(clip32(acc));
         end
         cur_v = nxt_v;
      end
      // denormalize and clamp
      vf = round_shift(longint'(cur_v[0]) * longint'(out_std), 16) + longint'(out_mean);
      e.clamp_code = CLAMP_NONE;
      if (vf < 0) begin
         vf = 0;
         e.clamp_code = CLAMP_ZERO;
      end else if (vf > 65536) begin
         vf = 65536;
         e.clamp_code = CLAMP_ONE;
      end
      e.volume_fraction  = 17'(vf);
      e.log_domain_error = logerr;
      e.saturated        = sat_seen;
      clamp_seen[e.clamp_code]++;
      if (logerr) log_errors++;
      if (sat_seen) sat_results++;
      expected_fractions.push_back(e);
   endfunction

   // accepted result beat against the oldest prediction
   function void check_result(rsp_type got);
      rsp_type e;
      if (expected_fractions.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result beat %p", got);
         return;
      end
      e = expected_fractions.pop_front();
      if (got.volume_fraction !== e.volume_fraction || got.clamp_code !== e.clamp_code ||
          got.log_domain_error !== e.log_domain_error || got.saturated !== e.saturated) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch: fraction exp %0d got %0d, clamp exp %0d got %0d",
                     e.volume_fraction, got.volume_fraction, e.clamp_code, got.clamp_code);
            $display("          log error exp %0d got %0d, saturated exp %0d got %0d",
                     e.log_domain_error, got.log_domain_error, e.saturated, got.saturated);
         end
      end
   endfunction

   function int pending();
      return expected_fractions.size();
   endfunction
endclass

module mlp_regression_inference_test;

   localparam int CYCLE_LIMIT = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_ACT_MODE;
   logic [31:0] csr_wdata = '0;

   volume_fraction_board board = new();
   int cycle_count = 0;
   int req_beats = 0;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int settings = 0;

   mlp_regression_inference dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // beat monitor and run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
      if (!reset) begin
         if (req_valid && !req_stall) begin
            board.note_beat(req_data);
            req_beats++;
         end
         if (rsp_valid && !rsp_stall) begin
            board.check_result(rsp_data);
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < rsp_stall_pct);
   end

   function automatic logic signed [31:0] rand_q(int span);
      int m;
      if ($urandom_range(7) == 0) return $urandom;
      m = $urandom_range(span);
      return $urandom_range(1) ? 32'(m) : -32'(m);
   endfunction

   function automatic req_type rand_req();
      req_type r;
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return r;
   endfunction

   task automatic send_beat(input req_type r);
      int seen;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data  = r;
      req_valid = 1'b1;
      seen = req_beats;
      do @(negedge clock); while (req_beats == seen);
   endtask

   task automatic send_write(input logic [2:0] sel, input logic [2:0] lay,
                             input logic [4:0] row, input logic [4:0] col,
                             input logic signed [31:0] word);
      req_type r;
      r = rand_req();
      r.func         = FUNC_WRITE;
      r.table_select = sel;
      r.layer_index  = lay;
      r.row_index    = row;
      r.col_index    = col;
      r.word_value   = word;
      send_beat(r);
   endtask

   task automatic send_predict(input logic signed [31:0] f0, f1, f2, f3, f4);
      req_type r;
      r = rand_req();
      r.func      = FUNC_PREDICT;
      r.feature_0 = f0;
      r.feature_1 = f1;
      r.feature_2 = f2;
      r.feature_3 = f3;
      r.feature_4 = f4;
      send_beat(r);
   endtask

   task automatic predict_random();
      logic signed [31:0] f4;
      case ($urandom_range(9))
         0: f4 = -32'($urandom_range(100000));
         1, 2: f4 = 32'($urandom_range(32'h7fff_ffff, 1));
         default: f4 = 32'($urandom_range(200 << 16, 1));
      endcase
      send_predict(rand_q(4 << 16), rand_q(4 << 16), rand_q(4 << 16), rand_q(4 << 16), f4);
   endtask

   // writes that must leave the network unchanged or hit valid addresses
   task automatic noise_write();
      case ($urandom_range(3))
         0: send_write($urandom_range(1) ? 3'd6 : 3'd7, $urandom, $urandom, $urandom, $urandom);
         1: send_write($urandom_range(1) ? SEL_MEAN : SEL_SCALE, $urandom,
                       $urandom_range(31, 5), $urandom, $urandom);
         2: send_write(SEL_WEIGHT, $urandom, $urandom, $urandom, rand_q(2 << 16));
         default: send_write(SEL_BIAS, $urandom, $urandom, $urandom, rand_q(2 << 16));
      endcase
   endtask

   function automatic logic signed [31:0] count_word(int n);
      if (n == 1 && $urandom_range(1)) return -32'($urandom_range(1000));
      if (n == 32 && $urandom_range(1)) return $urandom_range(1) ? S32_MAX : 32'd40;
      return 32'(n);
   endfunction

   // all eight layers, each reading no more than the previous layer produced
   task automatic build_network(input bit wide);
      int rows;
      int cols;
      int prev;
      prev = 5;
      for (int i = 0; i < 5; i++) begin
         send_write(SEL_MEAN, $urandom, i, $urandom, rand_q(2 << 16));
         send_write(SEL_SCALE, $urandom, i, $urandom, rand_q(2 << 16));
      end
      for (int l = 0; l < 8; l++) begin
         rows = $urandom_range(4, 1);
         cols = $urandom_range(prev > 4 ? 4 : prev, 1);
         if (wide && l == 0) begin
            rows = 32;
            cols = 5;
         end else if (wide && l == 1) begin
            rows = 1;
            cols = 32;
         end
         send_write(SEL_ROWS, l, $urandom, $urandom, count_word(rows));
         send_write(SEL_COLS, l, $urandom, $urandom, count_word(cols));
         for (int i = 0; i < rows; i++) begin
            send_write(SEL_BIAS, l, i, $urandom, rand_q(1 << 16));
            for (int j = 0; j < cols; j++) begin
               send_write(SEL_WEIGHT, l, i, j, rand_q(3 << 16));
            end
         end
         prev = rows;
      end
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] v);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      board.set_reg(idx, v);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // hold off until every prediction is back, then let the block settle
   task automatic drain();
      req_valid = 1'b0;
      while (board.pending() > 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset = 1'b0;
      for (int k = 0; k < 12; k++) begin
         if (k < 4) begin
            req_idle_pct  = 14;
            rsp_stall_pct = 78;
         end else if (k < 8) begin
            req_idle_pct  = 78;
            rsp_stall_pct = 14;
         end else begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         drain();
         settings++;
         csr_write(CSR_ACT_MODE, k % 4);
         case (k)
            0: csr_write(CSR_LAYER_COUNT, 0);
            1: begin
               csr_write(CSR_LAYER_COUNT, 15);
               csr_write(CSR_OUT_MEAN, S32_MAX);
               csr_write(CSR_OUT_STD, S32_MIN);
            end
            2: begin
               csr_write(CSR_LAYER_COUNT, 8);
               csr_write(CSR_OUT_MEAN, S32_MIN);
               csr_write(CSR_OUT_STD, S32_MAX);
            end
            default: begin
               csr_write(CSR_LAYER_COUNT, $urandom_range(8, 1));
               csr_write(CSR_OUT_MEAN, $urandom_range(65536));
               csr_write(CSR_OUT_STD, rand_q(2 << 16));
            end
         endcase
         build_network(k == 0 || k == 7);
         if (k == 0) begin
            // ignored writes, field extremes and the log domain edges
            send_write(3'd6, 3'd7, 5'd31, 5'd31, S32_MAX);
            send_write(3'd7, 3'd0, 5'd0, 5'd0, S32_MIN);
            send_write(SEL_MEAN, 3'd0, 5'd9, 5'd0, S32_MAX);
            send_write(SEL_SCALE, 3'd7, 5'd31, 5'd31, S32_MIN);
            send_predict(0, 0, 0, 0, 32'sd65536);
            send_predict(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX);
            send_predict(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN);
            send_predict(32'sd65536, -32'sd65536, 32'sd1, -32'sd1, 32'sd0);
            send_predict(32'sd8 <<< 16, -32'sd8 <<< 16, 0, 0, -32'sd1);
            send_predict(0, 0, 0, 0, 32'sd1);
            send_predict(0, 0, 0, 0, 32'sd256);
            send_predict(rand_q(1 << 16), 0, 0, 0, 32'sd10 <<< 16);
         end
         for (int n = 0; n < 8; n++) begin
            if ($urandom_range(99) < 15) noise_write();
            predict_random();
         end
      end
      drain();
      $display("%0d predictions and %0d table writes over %0d register settings",
               board.predicts, board.writes, settings);
      $display("clamps none/zero/one %0d/%0d/%0d, log errors %0d, saturated %0d",
               board.clamp_seen[0], board.clamp_seen[1], board.clamp_seen[2],
               board.log_errors, board.sat_results);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/mri_pkg.sv
rtl/mlp_regression_inference.sv
verif/mlp_regression_inference_test.sv
